// ===== rtl/elfr_pkg.sv =====
// ----------------------------------------------------------------------------
// elfr_pkg
// Shared constants and types of the escaped, length-framed byte receiver.
// ----------------------------------------------------------------------------
package elfr_pkg;

  localparam int BUFFER_DEPTH_DEFAULT = 256;

  localparam logic [8:0] MAX_LENGTH_RESET = 9'd200;
  localparam logic [7:0] ESCAPE_BYTE      = 8'h25;
  localparam logic [7:0] START_BYTE       = 8'h73;

  localparam logic [1:0] KIND_RECEIVE = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_TAKE    = 2'd2;

  // Request from the frame control to the payload memory.
  typedef struct packed {
    logic       wr_en;
    logic [8:0] wr_pos;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_index;
  } elfr_mem_req_t;

  // Result of one item, apart from the memory read data.
  typedef struct packed {
    logic       taken;
    logic [8:0] length;
    logic       is_read;
  } elfr_result_t;

endpackage

// ===== rtl/escaped_length_framed_receiver_top.sv =====
// ----------------------------------------------------------------------------
// escaped_length_framed_receiver_top: byte-stuffed, length-prefixed deframer
// A read item's memory data is registered, then passes the output register.
// One item per cycle while in_stall is low; at most one buffer access each.
// Reset clears control state and sets max_length to 200; buffer is not cleared.
// ----------------------------------------------------------------------------
module escaped_length_framed_receiver_top
  import elfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  input  logic [7:0]  read_index,
  input  logic [15:0] size_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        packet_taken,
  output logic [8:0]  packet_length,
  output logic [7:0]  read_data,
  input  logic        cfg_en,
  input  logic [8:0]  cfg_data
);

  logic          accept;
  elfr_mem_req_t mem_req;
  elfr_result_t  result;
  logic [7:0]    rd_data;

  assign accept = in_valid && !in_stall;

  elfr_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .byte_value (byte_value),
    .read_index (read_index),
    .size_limit (size_limit),
    .cfg_en     (cfg_en),
    .cfg_data   (cfg_data),
    .mem_req    (mem_req),
    .result     (result)
  );

  elfr_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  elfr_out u_out (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .result        (result),
    .rd_data       (rd_data),
    .out_stall     (out_stall),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .packet_taken  (packet_taken),
    .packet_length (packet_length),
    .read_data     (read_data)
  );

endmodule

// ===== rtl/elfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// elfr_ctrl
// Escape decoding, frame phase tracking, length check and packet take logic.
// ----------------------------------------------------------------------------
module elfr_ctrl
  import elfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    kind,
  input  logic [7:0]    byte_value,
  input  logic [7:0]    read_index,
  input  logic [15:0]   size_limit,
  input  logic          cfg_en,
  input  logic [8:0]    cfg_data,
  output elfr_mem_req_t mem_req,
  output elfr_result_t  result
);

  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_LEN_HI = 2'd1;
  localparam logic [1:0] PHASE_LEN_LO = 2'd2;
  localparam logic [1:0] PHASE_DATA   = 2'd3;

  logic [8:0]  max_length;
  logic        escape_pending, escape_pending_next;
  logic [1:0]  frame_phase, frame_phase_next;
  logic [15:0] declared_length, declared_length_next;
  logic [8:0]  write_position, write_position_next;

  logic        data_valid;
  logic [15:0] length_full;
  logic        length_ok;
  logic [8:0]  position_inc;
  logic        complete;
  logic [15:0] clipped;

  assign length_full  = declared_length | {8'h00, byte_value};
  assign length_ok    = (length_full != 16'd0) && (length_full <= {7'd0, max_length}) &&
                        (32'(length_full) <= BUFFER_DEPTH);
  assign position_inc = write_position + 9'd1;
  assign complete     = (declared_length != 16'd0) &&
                        ({7'd0, write_position} == declared_length);
  assign clipped      = (declared_length > size_limit) ? size_limit : declared_length;

  always_comb begin
    escape_pending_next  = escape_pending;
    frame_phase_next     = frame_phase;
    declared_length_next = declared_length;
    write_position_next  = write_position;
    data_valid           = 1'b0;
    mem_req              = '0;
    mem_req.wr_pos       = write_position;
    mem_req.wr_data      = byte_value;
    mem_req.rd_index     = read_index;
    result               = '0;

    if (accept) begin
      case (kind)
        KIND_RECEIVE: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            if (byte_value == START_BYTE) begin
              // A start always restarts, even in the middle of a frame.
              write_position_next = 9'd0;
              frame_phase_next    = PHASE_LEN_HI;
            end else begin
              data_valid = 1'b1;
            end
          end else if (byte_value == ESCAPE_BYTE) begin
            escape_pending_next = 1'b1;
          end else begin
            data_valid = 1'b1;
          end
        end
        KIND_READ: begin
          mem_req.rd_en  = 1'b1;
          result.is_read = 1'b1;
        end
        KIND_TAKE: begin
          if (complete) begin
            result.taken         = 1'b1;
            result.length        = clipped[8:0];
            declared_length_next = 16'd0;
            write_position_next  = 9'd0;
          end
        end
        default: begin
        end
      endcase
    end

    if (data_valid) begin
      case (frame_phase)
        PHASE_LEN_HI: begin
          declared_length_next = {byte_value, 8'h00};
          frame_phase_next     = PHASE_LEN_LO;
        end
        PHASE_LEN_LO: begin
          // A rejected length stays in declared_length but never completes.
          declared_length_next = length_full;
          frame_phase_next     = length_ok ? PHASE_DATA : PHASE_IDLE;
        end
        PHASE_DATA: begin
          mem_req.wr_en       = (32'(write_position) < BUFFER_DEPTH);
          write_position_next = position_inc;
          if ({7'd0, position_inc} == declared_length) begin
            frame_phase_next = PHASE_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length      <= MAX_LENGTH_RESET;
      escape_pending  <= 1'b0;
      frame_phase     <= PHASE_IDLE;
      declared_length <= 16'd0;
      write_position  <= 9'd0;
    end else begin
      if (cfg_en) begin
        max_length <= cfg_data;
      end
      escape_pending  <= escape_pending_next;
      frame_phase     <= frame_phase_next;
      declared_length <= declared_length_next;
      write_position  <= write_position_next;
    end
  end

`ifndef SYNTHESIS
  // The fill position never runs past the declared length.
  assert property (@(posedge clk) disable iff (rst)
    {7'd0, write_position} <= declared_length)
    else $error("write position beyond declared length");

  // In the payload phase the frame is still open and has a nonzero length.
  assert property (@(posedge clk) disable iff (rst)
    frame_phase == PHASE_DATA |->
      declared_length != 16'd0 && {7'd0, write_position} < declared_length)
    else $error("payload phase with a closed frame");

  // A lone escape byte always arms the escape for the next byte.
  assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_RECEIVE && !escape_pending && byte_value == ESCAPE_BYTE
      |=> escape_pending)
    else $error("escape byte not registered");
`endif

endmodule

// ===== rtl/elfr_store.sv =====
// ----------------------------------------------------------------------------
// elfr_store
// Payload buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module elfr_store
  import elfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  elfr_mem_req_t mem_req,
  output logic [7:0]    rd_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic          rd_ok;
  logic [7:0]    rd_raw;

  assign wr_addr     = AW'(mem_req.wr_pos);
  assign rd_addr     = AW'(mem_req.rd_index);
  assign rd_in_range = (32'(mem_req.rd_index) < BUFFER_DEPTH);

  // Only one item is taken per cycle, so a read never meets a write in the
  // same cycle, and a read right after a write already sees the new byte.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_ok  <= rd_in_range;
    end
  end

  assign rd_data = rd_ok ? rd_raw : 8'h00;

endmodule

// ===== rtl/elfr_out.sv =====
// ----------------------------------------------------------------------------
// elfr_out
// Read-wait stage and output register with the flow control between them.
// ----------------------------------------------------------------------------
module elfr_out
  import elfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  elfr_result_t result,
  input  logic [7:0]   rd_data,
  input  logic         out_stall,
  output logic         in_stall,
  output logic         out_valid,
  output logic         packet_taken,
  output logic [8:0]   packet_length,
  output logic [7:0]   read_data
);

  logic         a_valid;
  elfr_result_t a_res;
  logic         a_move;

  // The first stage waits for the memory read data; it moves on whenever
  // the output register is empty or is being transferred.
  assign a_move   = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= accept || (a_valid && !a_move);
      out_valid <= a_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_res <= result;
    end
    if (a_move) begin
      packet_taken  <= a_res.taken;
      packet_length <= a_res.length;
      read_data     <= a_res.is_read ? rd_data : 8'h00;
    end
  end

`ifndef SYNTHESIS
  // An item held in the first stage stays there unchanged.
  assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_move |=> a_valid && $stable(a_res))
    else $error("held item lost in read stage");

  // A take result never carries read data.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_taken |-> read_data == 8'h00)
    else $error("take result with read data");
`endif

endmodule
